// ===== hdl/jms_pkg.sv =====
// Shared types, codes and helpers for the JPEG marker segmenter.
`timescale 1ns / 1ps

package jms_pkg;

  // Parse phase of the byte stream.
  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_MARKER,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_SCAN
  } phase_t;

  // Byte roles.
  localparam logic [2:0] ROLE_PREFIX  = 3'd0;
  localparam logic [2:0] ROLE_MARKER  = 3'd1;
  localparam logic [2:0] ROLE_LEN_HI  = 3'd2;
  localparam logic [2:0] ROLE_LEN_LO  = 3'd3;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd4;
  localparam logic [2:0] ROLE_SCAN    = 3'd5;
  localparam logic [2:0] ROLE_IGNORED = 3'd6;

  // Section types.
  localparam logic [1:0] SEC_SEGMENT = 2'd0;
  localparam logic [1:0] SEC_START   = 2'd1;
  localparam logic [1:0] SEC_END     = 2'd2;
  localparam logic [1:0] SEC_SCAN    = 2'd3;

  // Byte values that the parser looks for.
  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_00  = 8'h00;
  localparam logic [7:0] CODE_SOI = 8'hD8;
  localparam logic [7:0] CODE_EOI = 8'hD9;
  localparam logic [7:0] CODE_SOS = 8'hDA;

  // Result queue geometry.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  role;
    logic [1:0]  section_type;
    logic [15:0] section_index;
    logic [31:0] total_bytes;
    logic        error_flag;
    logic        last;
  } result_t;

  // Up to two results produced by one accepted input byte.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v, input logic en);
    logic [31:0] res;
    res = v;
    if (en && (v != 32'hFFFF_FFFF)) begin
      res = v + 32'd1;
    end
    return res;
  endfunction

endpackage

// ===== hdl/jms_in_if.sv =====
// Input byte channel of the JPEG marker segmenter.
`timescale 1ns / 1ps

interface jms_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ===== hdl/jms_out_if.sv =====
// Labeled result channel of the JPEG marker segmenter.
`timescale 1ns / 1ps

interface jms_out_if ();
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [2:0]  role;
  logic [1:0]  section_type;
  logic [15:0] section_index;
  logic [31:0] total_bytes;
  logic        error_flag;
  logic        last;

  modport source (output valid, output out_byte, output role, output section_type,
                  output section_index, output total_bytes, output error_flag,
                  output last, input ready);
  modport sink (input valid, input out_byte, input role, input section_type,
                input section_index, input total_bytes, input error_flag,
                input last, output ready);
endinterface

// ===== hdl/jms_labeler.sv =====
// Parse state and per-byte labeling logic of the JPEG marker segmenter.
`timescale 1ns / 1ps

module jms_labeler import jms_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  output push_t      push
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  current_type_r, current_type_nxt;
  logic [7:0]  length_high_r, length_high_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic        held_ff_r, held_ff_nxt;
  logic [15:0] section_counter_r, section_counter_nxt;
  logic [31:0] byte_counter_r, byte_counter_nxt;
  logic        halted_r, halted_nxt;

  logic [1:0]  n;
  logic [7:0]  byte0;
  logic [2:0]  role0;
  logic [2:0]  role1;
  logic        begin_sec;
  logic [15:0] len16;
  logic [15:0] bl_dec;
  logic [1:0]  code_type;
  logic [31:0] cnt0;
  logic [31:0] cnt1;
  phase_t      after_header;

  assign len16        = {length_high_r, in_byte};
  assign bl_dec       = (bytes_left_r != 16'd0) ? (bytes_left_r - 16'd1) : bytes_left_r;
  assign after_header = (current_type_r == SEC_SCAN) ? PH_SCAN : PH_PREFIX;

  always_comb begin
    unique case (in_byte)
      CODE_SOI: code_type = SEC_START;
      CODE_EOI: code_type = SEC_END;
      CODE_SOS: code_type = SEC_SCAN;
      default:  code_type = SEC_SEGMENT;
    endcase
  end

  always_comb begin
    phase_nxt           = phase_r;
    current_type_nxt    = current_type_r;
    length_high_nxt     = length_high_r;
    bytes_left_nxt      = bytes_left_r;
    held_ff_nxt         = held_ff_r;
    section_counter_nxt = section_counter_r;
    halted_nxt          = halted_r;
    n                   = 2'd0;
    byte0               = in_byte;
    role0               = ROLE_IGNORED;
    role1               = ROLE_IGNORED;
    begin_sec           = 1'b0;

    if (halted_r) begin
      n = 2'd1;
    end else begin
      unique case (phase_r)
        PH_MARKER: begin
          if (in_byte == BYTE_00 || in_byte == BYTE_FF) begin
            halted_nxt  = 1'b1;
            held_ff_nxt = 1'b0;
            n           = 2'd2;
            byte0       = BYTE_FF;
          end else begin
            begin_sec = 1'b1;
          end
        end
        PH_LEN_HI: begin
          length_high_nxt = in_byte;
          phase_nxt       = PH_LEN_LO;
          n               = 2'd1;
          role0           = ROLE_LEN_HI;
        end
        PH_LEN_LO: begin
          n = 2'd1;
          if (len16 < 16'd2) begin
            halted_nxt  = 1'b1;
            held_ff_nxt = 1'b0;
          end else begin
            bytes_left_nxt = len16 - 16'd2;
            phase_nxt      = (len16 == 16'd2) ? after_header : PH_PAYLOAD;
            role0          = ROLE_LEN_LO;
          end
        end
        PH_PAYLOAD: begin
          bytes_left_nxt = bl_dec;
          if (bl_dec == 16'd0) begin
            phase_nxt = after_header;
          end
          n     = 2'd1;
          role0 = ROLE_PAYLOAD;
        end
        PH_SCAN: begin
          if (!held_ff_r) begin
            if (in_byte == BYTE_FF) begin
              held_ff_nxt = 1'b1;
            end else begin
              n     = 2'd1;
              role0 = ROLE_SCAN;
            end
          end else if (in_byte == BYTE_00) begin
            // Stuffed zero: the held 0xFF and the zero are both scan data.
            held_ff_nxt = 1'b0;
            n           = 2'd2;
            byte0       = BYTE_FF;
            role0       = ROLE_SCAN;
            role1       = ROLE_SCAN;
          end else if (in_byte == BYTE_FF) begin
            // Fill byte: release the older 0xFF and keep holding the new one.
            n     = 2'd1;
            byte0 = BYTE_FF;
            role0 = ROLE_SCAN;
          end else begin
            begin_sec = 1'b1;
          end
        end
        default: begin
          if (in_byte == BYTE_FF) begin
            held_ff_nxt = 1'b1;
            phase_nxt   = PH_MARKER;
          end else begin
            halted_nxt  = 1'b1;
            held_ff_nxt = 1'b0;
            n           = 2'd1;
          end
        end
      endcase
    end

    if (begin_sec) begin
      if (section_counter_r != 16'hFFFF) begin
        section_counter_nxt = section_counter_r + 16'd1;
      end
      current_type_nxt = code_type;
      held_ff_nxt      = 1'b0;
      phase_nxt        = (code_type == SEC_START || code_type == SEC_END) ?
                         PH_PREFIX : PH_LEN_HI;
      n                = 2'd2;
      byte0            = BYTE_FF;
      role0            = ROLE_PREFIX;
      role1            = ROLE_MARKER;
    end
  end

  // The second result sees the count already advanced by the first.
  assign cnt0 = sat_inc32(byte_counter_r, role0 != ROLE_IGNORED);
  assign cnt1 = sat_inc32(cnt0, role1 != ROLE_IGNORED);

  always_comb begin
    unique case (n)
      2'd1:    byte_counter_nxt = cnt0;
      2'd2:    byte_counter_nxt = cnt1;
      default: byte_counter_nxt = byte_counter_r;
    endcase
  end

  always_comb begin
    push.n                = accept ? n : 2'd0;
    push.r0.out_byte      = byte0;
    push.r0.role          = role0;
    push.r0.section_type  = current_type_nxt;
    push.r0.section_index = section_counter_nxt;
    push.r0.total_bytes   = cnt0;
    push.r0.error_flag    = halted_nxt;
    push.r0.last          = (n == 2'd1);
    push.r1.out_byte      = in_byte;
    push.r1.role          = role1;
    push.r1.section_type  = current_type_nxt;
    push.r1.section_index = section_counter_nxt;
    push.r1.total_bytes   = cnt1;
    push.r1.error_flag    = halted_nxt;
    push.r1.last          = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_PREFIX;
      current_type_r    <= SEC_SEGMENT;
      length_high_r     <= 8'd0;
      bytes_left_r      <= 16'd0;
      held_ff_r         <= 1'b0;
      section_counter_r <= 16'd0;
      byte_counter_r    <= 32'd0;
      halted_r          <= 1'b0;
    end else if (accept) begin
      phase_r           <= phase_nxt;
      current_type_r    <= current_type_nxt;
      length_high_r     <= length_high_nxt;
      bytes_left_r      <= bytes_left_nxt;
      held_ff_r         <= held_ff_nxt;
      section_counter_r <= section_counter_nxt;
      byte_counter_r    <= byte_counter_nxt;
      halted_r          <= halted_nxt;
    end
  end

`ifndef SYNTH
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("error state left without reset");

  a_halt_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !held_ff_r)
    else $error("a 0xFF is held while halted");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> (!push.r0.last && push.r1.last))
    else $error("last flag misplaced on a result pair");
`endif

endmodule

// ===== hdl/jms_out_queue.sv =====
// Small result queue that lets one request push two results while the sink stalls.
`timescale 1ns / 1ps

module jms_out_queue import jms_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  output logic       space_ok,
  jms_out_if.source  out_ch
);

  result_t        mem [QDEPTH];
  logic [QAW-1:0] head_r;
  logic [QAW-1:0] tail_r;
  logic [QCW-1:0] count_r;
  logic           pop;
  result_t        head_res;

  assign pop      = out_ch.valid && out_ch.ready;
  // Room for two results is kept so that any input can be taken.
  assign space_ok = (count_r <= QCW'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[tail_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[tail_r + QAW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      tail_r  <= tail_r + QAW'(push.n);
      head_r  <= head_r + QAW'(pop);
      count_r <= count_r + QCW'(push.n) - QCW'(pop);
    end
  end

  assign head_res             = mem[head_r];
  assign out_ch.valid         = (count_r != '0);
  assign out_ch.out_byte      = head_res.out_byte;
  assign out_ch.role          = head_res.role;
  assign out_ch.section_type  = head_res.section_type;
  assign out_ch.section_index = head_res.section_index;
  assign out_ch.total_bytes   = head_res.total_bytes;
  assign out_ch.error_flag    = head_res.error_flag;
  assign out_ch.last          = head_res.last;

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QDEPTH))
    else $error("result queue overflow");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> space_ok)
    else $error("results pushed without room");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd0 && !pop) |=> $stable(count_r))
    else $error("queue count moved without push or pop");
`endif

endmodule

// ===== hdl/jpeg_marker_segmenter.sv =====
// Results are registered in the result queue and presented on out_ch from its head.
// Throughput: one byte per cycle while in_ch.ready is high; a byte that yields
// a held 0xFF plus itself gives two results, which the four-entry queue absorbs.
// in_ch.ready is high while the queue has room for two results.
// Reset: synchronous active-low rst_n returns to expecting a prefix, clears all
// counters and the error flag, and empties the result queue.
`timescale 1ns / 1ps

module jpeg_marker_segmenter import jms_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  jms_in_if.sink    in_ch,
  jms_out_if.source out_ch
);

  push_t push;
  logic  space_ok;
  logic  accept;

  assign in_ch.ready = space_ok;
  assign accept      = in_ch.valid && space_ok;

  jms_labeler u_labeler (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_ch.in_byte),
    .push    (push)
  );

  jms_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_ch   (out_ch)
  );

endmodule

// ===== tb/tb_jpeg_marker_segmenter.sv =====
// Self-checking testbench that streams JPEG-like bytes through the marker segmenter.
`timescale 1ns / 1ps

module tb_jpeg_marker_segmenter;
  import jms_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int FILE_BYTES = 1030;

  // Ways the stream is broken at its tail; each one halts the parser for good.
  localparam int TAIL_BAD_PREFIX = 0;
  localparam int TAIL_BAD_CODE   = 1;
  localparam int TAIL_SHORT_LEN  = 2;

  typedef struct packed {
    logic       pause;
    logic [7:0] b;
  } file_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  jms_in_if  in_ch ();
  jms_out_if out_ch ();

  jpeg_marker_segmenter u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  file_item_t file_q[$];
  result_t    label_q[$];
  int         n_fed = 0;
  int         n_bad = 0;
  int         cyc = 0;
  int         idle_cyc = 0;
  logic       calm;

  // Neither side inserts random gaps inside this window.
  assign calm = (cyc >= 300) && (cyc < 800);

  // Parser state as seen by the predictor.
  phase_t      prs_phase = PH_PREFIX;
  logic [1:0]  sec_type = SEC_SEGMENT;
  logic [7:0]  len_high = '0;
  logic [15:0] left_cnt = '0;
  logic        ff_held = 1'b0;
  logic [15:0] sec_count = '0;
  logic [31:0] byte_count = '0;
  logic        stuck = 1'b0;

  result_t lab_buf[$];
  int      lab_n;

  function automatic void put_label(input logic [7:0] b, input logic [2:0] role);
    result_t r;
    if (role != ROLE_IGNORED && byte_count != 32'hFFFF_FFFF) begin
      byte_count = byte_count + 32'd1;
    end
    r.out_byte      = b;
    r.role          = role;
    r.section_type  = sec_type;
    r.section_index = sec_count;
    r.total_bytes   = byte_count;
    r.error_flag    = stuck;
    r.last          = 1'b0;
    lab_buf.push_back(r);
    lab_n++;
  endfunction

  function automatic void go_halted();
    stuck   = 1'b1;
    ff_held = 1'b0;
  endfunction

  function automatic phase_t header_done_phase();
    return (sec_type == SEC_SCAN) ? PH_SCAN : PH_PREFIX;
  endfunction

  function automatic void open_section(input logic [7:0] code);
    if (sec_count != 16'hFFFF) begin
      sec_count = sec_count + 16'd1;
    end
    if (code == CODE_SOI) begin
      sec_type = SEC_START;
    end else if (code == CODE_EOI) begin
      sec_type = SEC_END;
    end else if (code == CODE_SOS) begin
      sec_type = SEC_SCAN;
    end else begin
      sec_type = SEC_SEGMENT;
    end
    ff_held   = 1'b0;
    prs_phase = (sec_type == SEC_START || sec_type == SEC_END) ? PH_PREFIX : PH_LEN_HI;
    put_label(BYTE_FF, ROLE_PREFIX);
    put_label(code, ROLE_MARKER);
  endfunction

  // Works out the labels that one accepted byte produces and queues them.
  function automatic void label_byte(input logic [7:0] b);
    logic [15:0] len;
    lab_n = 0;
    lab_buf.delete();
    if (stuck) begin
      put_label(b, ROLE_IGNORED);
    end else begin
      case (prs_phase)
        PH_MARKER: begin
          if (b == BYTE_00 || b == BYTE_FF) begin
            go_halted();
            put_label(BYTE_FF, ROLE_IGNORED);
            put_label(b, ROLE_IGNORED);
          end else begin
            open_section(b);
          end
        end
        PH_LEN_HI: begin
          len_high  = b;
          prs_phase = PH_LEN_LO;
          put_label(b, ROLE_LEN_HI);
        end
        PH_LEN_LO: begin
          len = {len_high, b};
          if (len < 16'd2) begin
            go_halted();
            put_label(b, ROLE_IGNORED);
          end else begin
            left_cnt  = len - 16'd2;
            prs_phase = (left_cnt == 0) ? header_done_phase() : PH_PAYLOAD;
            put_label(b, ROLE_LEN_LO);
          end
        end
        PH_PAYLOAD: begin
          if (left_cnt != 0) begin
            left_cnt = left_cnt - 16'd1;
          end
          if (left_cnt == 0) begin
            prs_phase = header_done_phase();
          end
          put_label(b, ROLE_PAYLOAD);
        end
        PH_SCAN: begin
          if (!ff_held) begin
            if (b == BYTE_FF) begin
              ff_held = 1'b1;
            end else begin
              put_label(b, ROLE_SCAN);
            end
          end else if (b == BYTE_00) begin
            ff_held = 1'b0;
            put_label(BYTE_FF, ROLE_SCAN);
            put_label(BYTE_00, ROLE_SCAN);
          end else if (b == BYTE_FF) begin
            // The earlier 0xFF is data; this one is now the held candidate.
            put_label(BYTE_FF, ROLE_SCAN);
          end else begin
            open_section(b);
          end
        end
        default: begin
          if (b == BYTE_FF) begin
            ff_held   = 1'b1;
            prs_phase = PH_MARKER;
          end else begin
            go_halted();
            put_label(b, ROLE_IGNORED);
          end
        end
      endcase
    end
    if (lab_n > 0) begin
      lab_buf[lab_n - 1].last = 1'b1;
    end
    for (int i = 0; i < lab_n; i++) begin
      label_q.push_back(lab_buf[i]);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      n_bad++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // Driver: offers the file bytes in order; a pause entry holds it until all labels are in.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        label_byte(in_ch.in_byte);
        void'(file_q.pop_front());
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (file_q.size() != 0 && file_q[0].pause && label_q.size() == 0) begin
          void'(file_q.pop_front());
        end
        if (file_q.size() != 0 && !file_q[0].pause && (calm || $urandom_range(99) >= 15)) begin
          in_ch.valid   <= 1'b1;
          in_ch.in_byte <= file_q[0].b;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every accepted label is compared with the oldest predicted one.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 15);
      if (out_ch.valid && out_ch.ready) begin
        if (label_q.size() == 0) begin
          n_bad++;
          $display("%0t: unexpected result, expected none, actual byte %0h role %0d",
                   $time, out_ch.out_byte, out_ch.role);
        end else begin
          want = label_q.pop_front();
          check_field("out_byte", 32'(want.out_byte), 32'(out_ch.out_byte));
          check_field("role", 32'(want.role), 32'(out_ch.role));
          check_field("section_type", 32'(want.section_type), 32'(out_ch.section_type));
          check_field("section_index", 32'(want.section_index), 32'(out_ch.section_index));
          check_field("total_bytes", want.total_bytes, out_ch.total_bytes);
          check_field("error_flag", 32'(want.error_flag), 32'(out_ch.error_flag));
          check_field("last", 32'(want.last), 32'(out_ch.last));
        end
      end
    end
  end

  // Watchdog on cycles in which neither side moves a request.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cyc <= 0;
      end else begin
        idle_cyc <= idle_cyc + 1;
      end
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic add_byte(input logic [7:0] b);
    file_q.push_back('{pause: 1'b0, b: b});
    n_fed++;
  endtask

  task automatic add_pause();
    file_q.push_back('{pause: 1'b1, b: 8'h00});
  endtask

  task automatic add_bytes(input logic [7:0] seq[]);
    foreach (seq[i]) begin
      add_byte(seq[i]);
    end
  endtask

  // Entropy-coded data; a 0xFF is only ever followed by a stuffing 0x00 or another 0xFF.
  task automatic add_scan(input int n);
    logic [7:0] b;
    logic [7:0] prev;
    prev = 8'h00;
    for (int i = 0; i < n; i++) begin
      if (prev == BYTE_FF) begin
        b = ($urandom_range(1) == 0) ? BYTE_00 : BYTE_FF;
      end else if ($urandom_range(99) < 20) begin
        b = BYTE_FF;
      end else begin
        b = 8'($urandom_range(255));
      end
      add_byte(b);
      prev = b;
    end
  endtask

  task automatic add_random_section();
    int         pick;
    int         len;
    logic [7:0] code;
    pick = $urandom_range(99);
    if (pick < 8) begin
      code = CODE_SOI;
    end else if (pick < 14) begin
      code = CODE_EOI;
    end else if (pick < 40) begin
      code = CODE_SOS;
    end else begin
      code = 8'($urandom_range(254, 1));
      if (code == CODE_SOI || code == CODE_EOI || code == CODE_SOS) begin
        code = 8'hC4;
      end
    end
    add_byte(BYTE_FF);
    add_byte(code);
    if (code != CODE_SOI && code != CODE_EOI) begin
      // Now and then a length with a nonzero high byte.
      len = ($urandom_range(99) < 3) ? $urandom_range(300, 256) : $urandom_range(14, 2);
      add_byte(8'(len >> 8));
      add_byte(8'(len));
      for (int i = 0; i < len - 2; i++) begin
        add_byte(8'($urandom_range(255)));
      end
      if (code == CODE_SOS) begin
        add_scan($urandom_range(24));
      end
    end
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    out_ch.ready  = 1'b0;

    // Start, a table with a 0xFF in its payload, a scan with stuffing, then lowest
    // and highest marker codes with empty payloads, and the end marker.
    add_bytes('{BYTE_FF, CODE_SOI});
    add_bytes('{BYTE_FF, 8'hC4, 8'h00, 8'h04, BYTE_FF, BYTE_00});
    add_bytes('{BYTE_FF, CODE_SOS, 8'h00, 8'h02});
    add_bytes('{8'h00, BYTE_FF, BYTE_00, BYTE_FF, BYTE_FF, BYTE_00, 8'h7F});
    add_bytes('{BYTE_FF, 8'h01, 8'h00, 8'h02});
    add_bytes('{BYTE_FF, 8'hFE, 8'h00, 8'h02});
    add_bytes('{BYTE_FF, CODE_EOI});
    add_pause();

    while (n_fed < FILE_BYTES) begin
      add_random_section();
      if ($urandom_range(99) < 2) begin
        add_pause();
      end
    end

    // The tail breaks the stream in one of three ways; the parser stays halted after.
    add_bytes('{BYTE_FF, CODE_EOI});
    case ($urandom_range(2))
      TAIL_BAD_PREFIX: add_byte(8'($urandom_range(254)));
      TAIL_BAD_CODE: begin
        add_byte(BYTE_FF);
        add_byte(($urandom_range(1) == 0) ? BYTE_00 : BYTE_FF);
      end
      default: begin
        add_bytes('{BYTE_FF, 8'hC0, 8'h00});
        add_byte(8'($urandom_range(1)));
      end
    endcase
    repeat (8) begin
      add_byte(8'($urandom_range(255)));
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (file_q.size() != 0 || label_q.size() != 0 || in_ch.valid) begin
      @(negedge clk);
    end
    repeat (20) @(posedge clk);

    if (n_bad == 0 && label_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
